### sv/lkvc_pkg.sv
package lkvc_pkg;

  typedef enum logic [1:0] {
    ACT_GET    = 2'd0,
    ACT_CHECK  = 2'd1,
    ACT_PUT    = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_EXISTS  = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EVICT,
    S_UPDATE,
    S_OUTPUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // take the input transaction
    logic lookup;    // register match and oldest-slot results
    logic evict;     // drop the oldest entry
    logic update;    // apply the action
    logic emit;      // load the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic   hit;
    logic   full;
    logic   any_valid;
    action_t action;
  } dp_status_t;

  localparam int COUNT_BITS = 5;
  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_CAPACITY = 2'd0;

endpackage

### sv/lru_key_value_cache_unit.sv
// Channel  | Direction | Content
// s_axis   | in        | tdata: action[1:0], key[65:2], value[97:66], zero to bit 103
// m_axis   | out       | tdata: status[1:0], found_value[33:2], entry_count[38:34],
//          |           |        released_valid[39], released_key[103:40],
//          |           |        released_value[135:104]
// apb      | in/out    | capacity register at address 0
// Each transaction passes through capture, key match, eviction and update,
// then loads the output register; the sequencer handles one at a time.
// Reset clears the valid bits, the count and the output register; capacity
// returns to 16. A stalled result lets one further transaction run up to the
// output stage, where it waits until the stalled result is taken.
module lru_key_value_cache_unit #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // action, key, value
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // status, found_value, entry_count,
                                       // released_valid, released_key, released_value
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [lkvc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  lkvc_pkg::dp_cmd_t    cmd;
  lkvc_pkg::dp_status_t sts;
  logic       busy;
  logic [4:0] capacity;
  logic       out_valid;
  logic       in_fire;

  logic [1:0]  o_status;
  logic [31:0] o_found;
  logic [4:0]  o_count;
  logic        o_rel_valid;
  logic [63:0] o_rel_key;
  logic [31:0] o_rel_value;

  assign pready = 1'b1;
  assign prdata = (paddr == lkvc_pkg::ADDR_CAPACITY) ? {27'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
    end else if (psel && penable && pwrite && paddr == lkvc_pkg::ADDR_CAPACITY) begin
      capacity <= pwdata[4:0];
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // The output register is free when empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {o_rel_value, o_rel_key, o_rel_valid, o_count, o_found, o_status};

  lkvc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_free(!out_valid || m_axis_tready),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  lkvc_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .capacity(capacity),
    .in_action(s_axis_tdata[1:0]), .in_key(s_axis_tdata[65:2]),
    .in_value(s_axis_tdata[97:66]),
    .o_status(o_status), .o_found(o_found), .o_count(o_count),
    .o_rel_valid(o_rel_valid), .o_rel_key(o_rel_key), .o_rel_value(o_rel_value)
  );

  a_no_emit_lost: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_busy_after_fire: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready) else $error("accepted while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || m_axis_tready)) else $error("overwrote result");

endmodule

### sv/lkvc_ctrl.sv
module lkvc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_free,
  input  lkvc_pkg::dp_status_t sts,
  output lkvc_pkg::dp_cmd_t   cmd,
  output logic                busy
);

  lkvc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      lkvc_pkg::S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_next = lkvc_pkg::S_LOOKUP;
        end
      end
      lkvc_pkg::S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = lkvc_pkg::S_EVICT;
      end
      lkvc_pkg::S_EVICT: begin
        if (sts.action == lkvc_pkg::ACT_PUT && !sts.hit && sts.full && sts.any_valid) begin
          cmd.evict = 1'b1;
        end
        state_next = lkvc_pkg::S_UPDATE;
      end
      lkvc_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = lkvc_pkg::S_OUTPUT;
      end
      lkvc_pkg::S_OUTPUT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          state_next = lkvc_pkg::S_IDLE;
        end
      end
      default: state_next = lkvc_pkg::S_IDLE;
    endcase
  end

endmodule

### sv/lkvc_datapath.sv
module lkvc_datapath #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lkvc_pkg::dp_cmd_t     cmd,
  output lkvc_pkg::dp_status_t  sts,
  input  logic [4:0]            capacity,
  input  logic [1:0]            in_action,
  input  logic [63:0]           in_key,
  input  logic [31:0]           in_value,
  output logic [1:0]            o_status,
  output logic [31:0]           o_found,
  output logic [4:0]            o_count,
  output logic                  o_rel_valid,
  output logic [63:0]           o_rel_key,
  output logic [31:0]           o_rel_value
);

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0]   slot_valid;
  logic [KEY_BITS-1:0]  slot_key   [ENTRIES];
  logic [VALUE_BITS-1:0] slot_value [ENTRIES];
  logic [IDX_BITS-1:0]  slot_age   [ENTRIES];
  logic [CNT_BITS-1:0]  valid_count;

  logic [1:0]            req_action;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  logic                  hit;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [IDX_BITS-1:0]   old_idx;
  logic                  rel_valid;
  logic [KEY_BITS-1:0]   rel_key;
  logic [VALUE_BITS-1:0] rel_value;
  logic [1:0]            res_status;
  logic [VALUE_BITS-1:0] res_found;

  // combinational match and oldest search (oldest has age == count-1)
  logic                  m_hit;
  logic [IDX_BITS-1:0]   m_idx;
  logic [IDX_BITS-1:0]   m_old;
  logic [CNT_BITS-1:0]   cap_eff;
  logic                  free_found;
  logic [IDX_BITS-1:0]   free_idx;

  always_comb begin
    m_hit = 1'b0;
    m_idx = '0;
    m_old = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_key[i] == req_key && !m_hit) begin
        m_hit = 1'b1;
        m_idx = IDX_BITS'(i);
      end
      if (slot_valid[i] && CNT_BITS'(slot_age[i]) == valid_count - 1'b1) begin
        m_old = IDX_BITS'(i);
      end
    end
    free_found = 1'b0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!slot_valid[i] && !free_found) begin
        free_found = 1'b1;
        free_idx = IDX_BITS'(i);
      end
    end
    if (capacity == 5'd0) cap_eff = CNT_BITS'(1);
    else if ({27'd0, capacity} > ENTRIES) cap_eff = CNT_BITS'(ENTRIES);
    else cap_eff = CNT_BITS'(capacity);
  end

  assign sts.hit = hit;
  assign sts.full = valid_count >= cap_eff;
  assign sts.any_valid = |slot_valid;
  assign sts.action = lkvc_pkg::action_t'(req_action);

  logic [IDX_BITS-1:0] ref_age;
  assign ref_age = slot_age[hit_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      valid_count <= '0;
      o_status <= '0;
      o_found <= '0;
      o_count <= '0;
      o_rel_valid <= 1'b0;
      o_rel_key <= '0;
      o_rel_value <= '0;
    end else begin
      if (cmd.capture) begin
        req_action <= in_action;
        req_key <= in_key[KEY_BITS-1:0];
        req_value <= in_value[VALUE_BITS-1:0];
        rel_valid <= 1'b0;
        rel_key <= '0;
        rel_value <= '0;
      end
      if (cmd.lookup) begin
        hit <= m_hit;
        hit_idx <= m_idx;
        old_idx <= m_old;
      end
      if (cmd.evict) begin
        // oldest has the top age, so no other age needs closing
        slot_valid[old_idx] <= 1'b0;
        valid_count <= valid_count - 1'b1;
        rel_valid <= 1'b1;
        rel_key <= slot_key[old_idx];
        rel_value <= slot_value[old_idx];
      end
      if (cmd.update) begin
        res_status <= lkvc_pkg::ST_OK;
        res_found <= '0;
        case (lkvc_pkg::action_t'(req_action))
          lkvc_pkg::ACT_GET, lkvc_pkg::ACT_PUT: begin
            if (hit) begin
              if (req_action == lkvc_pkg::ACT_GET) res_found <= slot_value[hit_idx];
              else res_status <= lkvc_pkg::ST_EXISTS;
              for (int i = 0; i < ENTRIES; i++) begin
                if (slot_valid[i] && slot_age[i] < ref_age) slot_age[i] <= slot_age[i] + 1'b1;
              end
              slot_age[hit_idx] <= '0;
            end else if (req_action == lkvc_pkg::ACT_GET) begin
              res_status <= lkvc_pkg::ST_MISS;
            end else if (free_found) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (slot_valid[i]) slot_age[i] <= slot_age[i] + 1'b1;
              end
              slot_valid[free_idx] <= 1'b1;
              slot_key[free_idx] <= req_key;
              slot_value[free_idx] <= req_value;
              slot_age[free_idx] <= '0;
              valid_count <= valid_count + 1'b1;
            end
          end
          lkvc_pkg::ACT_CHECK: begin
            if (!hit) res_status <= lkvc_pkg::ST_MISS;
          end
          lkvc_pkg::ACT_REMOVE: begin
            if (!hit) begin
              res_status <= lkvc_pkg::ST_MISS;
            end else begin
              slot_valid[hit_idx] <= 1'b0;
              valid_count <= valid_count - 1'b1;
              rel_valid <= 1'b1;
              rel_key <= slot_key[hit_idx];
              rel_value <= slot_value[hit_idx];
              for (int i = 0; i < ENTRIES; i++) begin
                if (slot_valid[i] && slot_age[i] > ref_age) slot_age[i] <= slot_age[i] - 1'b1;
              end
            end
          end
          default: res_status <= lkvc_pkg::ST_OK;
        endcase
      end
      if (cmd.emit) begin
        o_status <= res_status;
        o_found <= 32'(res_found);
        o_count <= 5'(valid_count);
        o_rel_valid <= rel_valid;
        o_rel_key <= 64'(rel_key);
        o_rel_value <= 32'(rel_value);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CNT_BITS'(ENTRIES)) else $error("count above entries");
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == int'(valid_count)) else $error("count mismatch");
  a_evict_once: assert property (@(posedge clk) disable iff (rst)
    cmd.evict |=> !cmd.evict) else $error("double evict");

endmodule

### sim/lru_key_value_cache_unit_checker.sv
module lru_key_value_cache_unit_checker #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // action, key, value
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,   // status, found_value, entry_count,
                                       // released_valid, released_key, released_value
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] released_value;
    logic [63:0] released_key;
    logic        released_valid;
    logic [4:0]  entry_count;
    logic [31:0] found_value;
    lkvc_pkg::status_t status;
  } reply_t;

  logic        line_valid [ENTRIES];
  logic [63:0] line_key   [ENTRIES];
  logic [31:0] line_value [ENTRIES];
  int          line_age   [ENTRIES];
  int          lines_used;
  logic [4:0]  cap_reg;
  reply_t      replies_due [$];

  // Moves line s to the front of the recency order.
  function automatic void promote(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (line_valid[i] && line_age[i] < line_age[s]) line_age[i]++;
    line_age[s] = 0;
  endfunction

  function automatic void evict_line(int s);
    line_valid[s] = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (line_valid[i] && line_age[i] > line_age[s]) line_age[i]--;
    if (lines_used > 0) lines_used--;
  endfunction

  function automatic reply_t serve_request(lkvc_pkg::action_t act, logic [63:0] key,
                                           logic [31:0] val);
    reply_t r;
    int hit;
    int cap;
    int old;
    int fr;
    r = '0;
    r.status = lkvc_pkg::ST_OK;
    hit = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (line_valid[i] && line_key[i] == key) hit = i;
    cap = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES ? ENTRIES : int'(cap_reg));
    case (act)
      lkvc_pkg::ACT_GET: begin
        if (hit < 0) r.status = lkvc_pkg::ST_MISS;
        else begin
          r.found_value = line_value[hit];
          promote(hit);
        end
      end
      lkvc_pkg::ACT_CHECK: begin
        if (hit < 0) r.status = lkvc_pkg::ST_MISS;
      end
      lkvc_pkg::ACT_PUT: begin
        if (hit >= 0) begin
          promote(hit);
          r.status = lkvc_pkg::ST_EXISTS;
        end else begin
          if (lines_used >= cap) begin
            old = -1;
            for (int i = 0; i < ENTRIES; i++)
              if (line_valid[i] && (old < 0 || line_age[i] > line_age[old])) old = i;
            if (old >= 0) begin
              r.released_valid = 1'b1;
              r.released_key = line_key[old];
              r.released_value = line_value[old];
              evict_line(old);
            end
          end
          fr = -1;
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!line_valid[i]) fr = i;
          if (fr >= 0) begin
            for (int j = 0; j < ENTRIES; j++)
              if (line_valid[j]) line_age[j]++;
            line_valid[fr] = 1'b1;
            line_key[fr] = key;
            line_value[fr] = val;
            line_age[fr] = 0;
            lines_used++;
          end
        end
      end
      default: begin
        if (hit < 0) r.status = lkvc_pkg::ST_MISS;
        else begin
          r.released_valid = 1'b1;
          r.released_key = line_key[hit];
          r.released_value = line_value[hit];
          evict_line(hit);
        end
      end
    endcase
    r.entry_count = lines_used[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
      lines_used = 0;
      cap_reg = 5'd16;
      replies_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) cap_reg = cfg_wdata[4:0];
      if (s_axis_tvalid && s_axis_tready)
        replies_due.push_back(serve_request(lkvc_pkg::action_t'(s_axis_tdata[1:0]),
                                            s_axis_tdata[65:2], s_axis_tdata[97:66]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = reply_t'(m_axis_tdata);
        if (replies_due.size() == 0) begin
          $display("%0t: result with none expected", $realtime);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.found_value !== want.found_value)
            report_mismatch("found_value", got.found_value, want.found_value);
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
          if (got.released_valid !== want.released_valid)
            report_mismatch("released_valid", got.released_valid, want.released_valid);
          if (got.released_key !== want.released_key)
            report_mismatch("released_key", got.released_key, want.released_key);
          if (got.released_value !== want.released_value)
            report_mismatch("released_value", got.released_value, want.released_value);
        end
      end
    end
    pending = replies_due.size();
  end
endmodule

### sim/lru_key_value_cache_unit_tb.sv
module lru_key_value_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_STALL = 400;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;  // action, key, value
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;       // status, found_value, entry_count,
                                    // released_valid, released_key, released_value
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [lkvc_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count;
  int           pending;

  // Idling knobs, in percent. The sink also runs one long hold-off on request.
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_stall_pct = 0;
  bit           long_stall = 1'b0;
  bit           stall_taken = 1'b0;
  int           stall_left = 0;
  int           idle_cycles = 0;

  // A small pool of keys makes hits, evictions and re-inserts frequent.
  logic [63:0]  key_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_key_value_cache_unit DUT (.*);

  lru_key_value_cache_unit_checker checker_i (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we(psel && penable && pwrite && pready), .cfg_wdata(pwdata),
    .fail_count, .pending
  );

  // The receiver stalls at random, or for a long stretch counted here.
  always @(negedge clk) begin
    if (long_stall && !stall_taken) begin
      stall_taken <= 1'b1;
      stall_left <= LONG_STALL;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // The watchdog counts cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lru_key_value_cache_unit_tb failed");
      $finish;
    end
  end

  // Offers one request and waits until the block takes it.
  task automatic send_request(lkvc_pkg::action_t act, logic [63:0] key, logic [31:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= {6'd0, val, key, act};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes capacity once every result is back; the extra cycles cover the
  // block's own pipeline.
  task automatic write_capacity(logic [31:0] cap);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= lkvc_pkg::ADDR_CAPACITY;
    pwdata <= cap;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Mostly pool keys so that the cache sees real traffic; some fully random.
  task automatic send_random;
    logic [63:0] key;
    key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(7)];
    send_request(lkvc_pkg::action_t'($urandom_range(3)), key, $urandom);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: extreme keys and values, every action, hits and misses,
    // a put on a present key, and eviction once the cache is full.
    send_request(lkvc_pkg::ACT_GET, 64'd0, 32'd0);
    send_request(lkvc_pkg::ACT_REMOVE, 64'd0, 32'd0);
    send_request(lkvc_pkg::ACT_PUT, 64'd0, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::ACT_PUT, '1, 32'd0);
    send_request(lkvc_pkg::ACT_CHECK, '1, 32'd5);
    send_request(lkvc_pkg::ACT_GET, 64'd0, 32'd0);
    send_request(lkvc_pkg::ACT_PUT, 64'd0, 32'd1);
    send_request(lkvc_pkg::ACT_CHECK, 64'd7, 32'd0);
    send_request(lkvc_pkg::ACT_REMOVE, '1, 32'd0);
    for (int i = 1; i <= 16; i++)
      send_request(lkvc_pkg::ACT_PUT, {32'hA5A5_0000, 32'(i)}, 32'(i));

    // Capacity sweep, zero and an out-of-range value included. Lowering it
    // below the count exercises eviction with too many entries held.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_capacity(32'd3);
        1: write_capacity(32'd0);
        2: write_capacity(32'd31);
        3: write_capacity(32'd1);
        4: write_capacity(32'd8);
        5: write_capacity(32'd16);
        6: write_capacity(32'hFFFF_FFE5);
        default: write_capacity(32'd16);
      endcase
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      if (ph == 2) long_stall = 1'b1;
      for (int n = 0; n < 172; n++) send_random();
    end
    s_axis_tvalid <= 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("lru_key_value_cache_unit_tb passed");
    else
      $display("lru_key_value_cache_unit_tb failed");
    $finish;
  end
endmodule

### sim.f
sv/lkvc_pkg.sv
sv/lkvc_ctrl.sv
sv/lkvc_datapath.sv
sv/lru_key_value_cache_unit.sv
sim/lru_key_value_cache_unit_checker.sv
sim/lru_key_value_cache_unit_tb.sv
